FILE: rtl/core/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned MaxIn = 65535;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  localparam logic [2:0] PH_OPEN = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_IDLE = 3'd4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_CTRL_END  = 8'h20;

  localparam logic [15:0] UTF8_ONE_MAX = 16'h007f;
  localparam logic [15:0] UTF8_TWO_MAX = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'he0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

  localparam logic [15:0] CAP_RESET = 16'hffff;

  // One run of results caused by a single input byte.
  typedef struct packed {
    logic [1:0]      count;   // number of results, 1 to 3
    logic [1:0]      kind;
    logic [2:0][7:0] bytes;   // data bytes, index 0 goes out first
    logic [15:0]     clen;
    logic [15:0]     used;
  } job_t;

  // Returns {valid, value} for one hex digit of either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, byte} for the single-character escapes.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/jsu_front.sv
// Front end: parses input bytes, tracks string state and builds result runs.
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            end_of_buffer,
  input  logic [15:0]     capacity,
  output logic            push,
  output jsu_pkg::job_t   job
);

  logic [2:0]  phase, phase_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] acc, acc_next;
  logic [15:0] emitted, emitted_next;
  logic [15:0] in_count, in_count_next;

  logic        fail;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] code;

  always_comb begin
    phase_next    = phase;
    hex_seen_next = hex_seen;
    acc_next      = acc;
    emitted_next  = emitted;
    in_count_next = in_count;
    fail          = 1'b0;
    job           = '0;
    hex           = jsu_pkg::hex_digit(in_byte);
    esc           = jsu_pkg::simple_escape(in_byte);
    code          = {acc[11:0], hex[3:0]};

    if (phase != jsu_pkg::PH_IDLE) begin
      if (in_count == 16'(jsu_pkg::MaxIn)) begin
        fail = 1'b1;
      end else begin
        in_count_next = in_count + 16'd1;
        if (end_of_buffer &&
            !(phase == jsu_pkg::PH_BODY && in_byte == jsu_pkg::CH_QUOTE)) begin
          fail = 1'b1;
        end else begin
          unique case (phase)
            jsu_pkg::PH_OPEN: begin
              if (in_byte == jsu_pkg::CH_QUOTE) phase_next = jsu_pkg::PH_BODY;
              else fail = 1'b1;
            end
            jsu_pkg::PH_BODY: begin
              if (in_byte == jsu_pkg::CH_QUOTE) begin
                job.count  = 2'd1;
                job.kind   = jsu_pkg::KIND_DONE;
                job.clen   = emitted;
                job.used   = in_count + 16'd1;
                phase_next = jsu_pkg::PH_IDLE;
              end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                phase_next = jsu_pkg::PH_ESC;
              end else if (in_byte < jsu_pkg::CH_CTRL_END || emitted >= capacity) begin
                fail = 1'b1;
              end else begin
                job.count    = 2'd1;
                job.kind     = jsu_pkg::KIND_DATA;
                job.bytes[0] = in_byte;
                emitted_next = emitted + 16'd1;
              end
            end
            jsu_pkg::PH_ESC: begin
              if (emitted >= capacity) begin
                fail = 1'b1;
              end else if (esc[8]) begin
                job.count    = 2'd1;
                job.kind     = jsu_pkg::KIND_DATA;
                job.bytes[0] = esc[7:0];
                emitted_next = emitted + 16'd1;
                phase_next   = jsu_pkg::PH_BODY;
              end else if (in_byte == jsu_pkg::CH_LOWER_U) begin
                hex_seen_next = 2'd0;
                acc_next      = '0;
                phase_next    = jsu_pkg::PH_HEX;
              end else begin
                fail = 1'b1;
              end
            end
            jsu_pkg::PH_HEX: begin
              if (!hex[4]) begin
                fail = 1'b1;
              end else if (hex_seen != 2'd3) begin
                acc_next      = code;
                hex_seen_next = hex_seen + 2'd1;
              end else begin
                hex_seen_next = 2'd0;
                acc_next      = '0;
                phase_next    = jsu_pkg::PH_BODY;
                job.kind      = jsu_pkg::KIND_DATA;
                // A one-byte code is emitted without a capacity check.
                if (code <= jsu_pkg::UTF8_ONE_MAX) begin
                  job.count    = 2'd1;
                  job.bytes[0] = code[7:0];
                  emitted_next = emitted + 16'd1;
                end else if (code <= jsu_pkg::UTF8_TWO_MAX) begin
                  if ({1'b0, emitted} + 17'd2 > {1'b0, capacity}) begin
                    fail = 1'b1;
                  end else begin
                    job.count    = 2'd2;
                    job.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b0, code[10:6]};
                    job.bytes[1] = jsu_pkg::UTF8_CONT | {2'b0, code[5:0]};
                    emitted_next = emitted + 16'd2;
                  end
                end else begin
                  if ({1'b0, emitted} + 17'd3 > {1'b0, capacity}) begin
                    fail = 1'b1;
                  end else begin
                    job.count    = 2'd3;
                    job.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0, code[15:12]};
                    job.bytes[1] = jsu_pkg::UTF8_CONT | {2'b0, code[11:6]};
                    job.bytes[2] = jsu_pkg::UTF8_CONT | {2'b0, code[5:0]};
                    emitted_next = emitted + 16'd3;
                  end
                end
              end
            end
            default: fail = 1'b1;
          endcase
        end
      end
      if (fail) begin
        job        = '0;
        job.count  = 2'd1;
        job.kind   = jsu_pkg::KIND_ERROR;
        phase_next = jsu_pkg::PH_IDLE;
      end
    end

    if (end_of_buffer) begin
      phase_next    = jsu_pkg::PH_OPEN;
      hex_seen_next = '0;
      acc_next      = '0;
      emitted_next  = '0;
      in_count_next = '0;
    end
  end

  assign push = accept && (job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= jsu_pkg::PH_OPEN;
      hex_seen <= '0;
      acc      <= '0;
      emitted  <= '0;
      in_count <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      hex_seen <= hex_seen_next;
      acc      <= acc_next;
      emitted  <= emitted_next;
      in_count <= in_count_next;
    end
  end

endmodule

FILE: rtl/core/jsu_queue.sv
// Short queue of result runs between the front end and the output serializer.
module jsu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::job_t   push_job,
  input  logic            pop,
  output jsu_pkg::job_t   head,
  output logic            empty,
  output logic            full
);

  jsu_pkg::job_t                 entries [jsu_pkg::QDepth];
  logic [jsu_pkg::QAw-1:0]       wr_ptr;
  logic [jsu_pkg::QAw-1:0]       rd_ptr;
  logic [jsu_pkg::QAw:0]         count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (jsu_pkg::QAw+1)'(jsu_pkg::QDepth));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= (jsu_pkg::QAw+1)'(jsu_pkg::QDepth))
    else $error("queue count beyond depth");
  a_head_nonzero: assert property (@(posedge clk) disable iff (rst)
      !empty |-> head.count != 2'd0)
    else $error("queued run holds no results");

endmodule

FILE: rtl/core/jsu_back.sv
// Back end: walks each queued run and drives the registered result port.
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  jsu_pkg::job_t   head,
  input  logic            empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic [15:0]     content_length,
  output logic [15:0]     bytes_consumed,
  output logic            last_of_run
);

  logic [1:0] sub;
  logic       load;
  logic       is_last;

  assign load    = (!out_valid || !out_stall) && !empty;
  assign is_last = (sub == head.count - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= is_last ? 2'd0 : sub + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= head.bytes[sub];
      kind           <= head.kind;
      content_length <= head.clen;
      bytes_consumed <= head.used;
      last_of_run    <= is_last;
    end
  end

  a_sub_in_run: assert property (@(posedge clk) disable iff (rst)
      !empty |-> sub < head.count)
    else $error("result index beyond run length");
  a_sub_idle: assert property (@(posedge clk) disable iff (rst)
      empty |-> sub == 2'd0)
    else $error("result index left open with no run queued");

endmodule

FILE: rtl/core/json_string_unescape.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
// A result passes from its input byte transfer through the run queue and the output register.
// Throughput: one input byte per cycle while the run queue is not full; a \u code
// of k bytes sends k results in turn, and a four-entry run queue absorbs such bursts.
// Reset (rst, synchronous): parser state, queue and output valid clear; the
// capacity register returns to 65535.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst,
  // Input byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [15:0] content_length,
  output logic [15:0] bytes_consumed,
  output logic        last_of_run,
  // Capacity register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] out_capacity
);

  logic          capacity;
  logic [15:0]   cap_reg;
  logic          in_accept;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  jsu_pkg::job_t push_job;
  jsu_pkg::job_t head;

  // The register takes a write in any cycle; software writes it only while
  // no string is in flight.
  assign cfg_ready = 1'b1;
  assign capacity  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= jsu_pkg::CAP_RESET;
    end else if (capacity) begin
      cap_reg <= out_capacity;
    end
  end

  // The front end holds off new bytes only when the run queue is full, so
  // a stalled output never blocks input until the queue has filled.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .capacity      (cap_reg),
    .push          (push),
    .job           (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end sends each run one result per transfer and flags its last one.
  jsu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .kind           (kind),
    .content_length (content_length),
    .bytes_consumed (bytes_consumed),
    .last_of_run    (last_of_run)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the streaming JSON string unescaper.
`timescale 1ns / 100ps

module tb_top;
  import jsu_pkg::*;

  // One result item as it leaves the result channel.
  typedef struct {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [15:0] clen;
    logic [15:0] used;
    logic        last;
  } unesc_result_t;

  typedef logic [7:0] byte_seq_t[$];

  // The checker keeps its own copy of the parser state and the capacity register.
  // Each accepted input byte is decoded here, and the results it should cause
  // are queued in order. Each result transfer is compared against the oldest entry.
  class unescape_checker;
    unesc_result_t decoded_queue[$];
    unesc_result_t run[$];
    int unsigned   errors;
    logic [15:0]   capacity;
    logic [2:0]    phase;
    int unsigned   hex_seen;
    logic [15:0]   code_acc;
    int unsigned   emitted;
    int unsigned   consumed;

    function new();
      errors   = 0;
      capacity = CAP_RESET;
      restart();
    endfunction

    function void restart();
      phase    = PH_OPEN;
      hex_seen = 0;
      code_acc = '0;
      emitted  = 0;
      consumed = 0;
    endfunction

    function int pending();
      return decoded_queue.size();
    endfunction

    function void add(logic [7:0] data, logic [1:0] kind, logic [15:0] clen,
                      logic [15:0] used);
      unesc_result_t r;
      r.data = data;
      r.kind = kind;
      r.clen = clen;
      r.used = used;
      r.last = 1'b0;
      run.push_back(r);
    endfunction

    function void take_input_byte(logic [7:0] c, logic eob);
      logic        fail;
      int          hv;
      int          ev;
      logic [15:0] u;
      fail = 1'b0;
      run.delete();
      if (phase != PH_IDLE) begin
        if (consumed >= MaxIn) begin
          fail = 1'b1;
        end else begin
          consumed++;
          // The last byte of a buffer is only good as the closing quote.
          if (eob && !(phase == PH_BODY && c == CH_QUOTE)) begin
            fail = 1'b1;
          end else begin
            case (phase)
              PH_OPEN: begin
                if (c == CH_QUOTE) phase = PH_BODY;
                else fail = 1'b1;
              end
              PH_BODY: begin
                if (c == CH_QUOTE) begin
                  add(8'h00, KIND_DONE, emitted[15:0], consumed[15:0]);
                  phase = PH_IDLE;
                end else if (c == CH_BACKSLASH) begin
                  phase = PH_ESC;
                end else if (c < CH_CTRL_END || emitted >= capacity) begin
                  fail = 1'b1;
                end else begin
                  add(c, KIND_DATA, '0, '0);
                  emitted++;
                end
              end
              PH_ESC: begin
                case (c)
                  "\"":    ev = 8'h22;
                  "\\":    ev = 8'h5c;
                  "/":     ev = 8'h2f;
                  "b":     ev = 8'h08;
                  "f":     ev = 8'h0c;
                  "n":     ev = 8'h0a;
                  "r":     ev = 8'h0d;
                  "t":     ev = 8'h09;
                  default: ev = -1;
                endcase
                // Capacity is checked first, whatever follows the backslash.
                if (emitted >= capacity) begin
                  fail = 1'b1;
                end else if (ev >= 0) begin
                  add(8'(ev), KIND_DATA, '0, '0);
                  emitted++;
                  phase = PH_BODY;
                end else if (c == CH_LOWER_U) begin
                  hex_seen = 0;
                  code_acc = '0;
                  phase    = PH_HEX;
                end else begin
                  fail = 1'b1;
                end
              end
              default: begin
                if (c >= "0" && c <= "9") hv = c - "0";
                else if (c >= "a" && c <= "f") hv = c - "a" + 10;
                else if (c >= "A" && c <= "F") hv = c - "A" + 10;
                else hv = -1;
                if (hv < 0) begin
                  fail = 1'b1;
                end else begin
                  u = {code_acc[11:0], 4'(hv)};
                  if (hex_seen < 3) begin
                    code_acc = u;
                    hex_seen++;
                  end else begin
                    hex_seen = 0;
                    code_acc = '0;
                    phase    = PH_BODY;
                    if (u <= UTF8_ONE_MAX) begin
                      add(u[7:0], KIND_DATA, '0, '0);
                      emitted++;
                    end else if (u <= UTF8_TWO_MAX) begin
                      if (emitted + 2 > capacity) begin
                        fail = 1'b1;
                      end else begin
                        add(UTF8_LEAD2 | {3'b000, u[10:6]}, KIND_DATA, '0, '0);
                        add(UTF8_CONT | {2'b00, u[5:0]}, KIND_DATA, '0, '0);
                        emitted += 2;
                      end
                    end else begin
                      if (emitted + 3 > capacity) begin
                        fail = 1'b1;
                      end else begin
                        add(UTF8_LEAD3 | {4'h0, u[15:12]}, KIND_DATA, '0, '0);
                        add(UTF8_CONT | {2'b00, u[11:6]}, KIND_DATA, '0, '0);
                        add(UTF8_CONT | {2'b00, u[5:0]}, KIND_DATA, '0, '0);
                        emitted += 3;
                      end
                    end
                  end
                end
              end
            endcase
          end
        end
        // An error replaces anything the byte would otherwise have produced.
        if (fail) begin
          run.delete();
          add(8'h00, KIND_ERROR, '0, '0);
          phase = PH_IDLE;
        end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) decoded_queue.push_back(run[i]);
      if (eob) restart();
    endfunction

    function void check_output(unesc_result_t got);
      unesc_result_t want;
      if (decoded_queue.size() == 0) begin
        $error("result with nothing expected: kind %0d out_byte %02h", got.kind, got.data);
        errors++;
        return;
      end
      want = decoded_queue.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, got.data);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.clen !== want.clen) begin
        $error("content_length: expected %0d, actual %0d", want.clen, got.clen);
        errors++;
      end
      if (got.used !== want.used) begin
        $error("bytes_consumed: expected %0d, actual %0d", want.used, got.used);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_buffer;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] content_length;
  logic [15:0] bytes_consumed;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cap_wdata;

  // Random idling on both channels is allowed only while this is set.
  logic idling_on;

  unescape_checker sb = new();

  json_string_unescape u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .kind           (kind),
    .content_length (content_length),
    .bytes_consumed (bytes_consumed),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .out_capacity   (cap_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result channel stalls in random bursts. The stall only changes on the
  // falling edge, so it is stable by the time the rising edge samples it.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Every result transfer is checked at the rising edge that completes it.
  always @(posedge clk) begin
    unesc_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.data = out_byte;
      got.kind = kind;
      got.clen = content_length;
      got.used = bytes_consumed;
      got.last = last_of_run;
      sb.check_output(got);
    end
  end

  // Presents one byte and holds it until the block takes it. The valid is left
  // high on return, so back-to-back bytes go in without a bubble. Any gap is
  // inserted here, at the start of the next call, rather than after a transfer.
  task automatic send_byte(input logic [7:0] value, input logic eob);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_byte       = value;
    end_of_buffer = eob;
    do @(posedge clk); while (in_stall);
    sb.take_input_byte(value, eob);
    @(negedge clk);
  endtask

  // Sends a whole buffer, with end_of_buffer set on its last byte.
  task automatic send_buffer(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // The capacity is changed only while the block is quiet. After the last
  // expected result, the task waits on for bytes that cause no result but
  // may still be in flight inside the block.
  task automatic write_capacity(input logic [15:0] value);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cap_wdata = value;
    do @(posedge clk); while (!cfg_ready);
    sb.capacity = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A raw byte from 0x20 to 0xff that is neither a quote nor a backslash.
  function automatic logic [7:0] raw_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  // Builds one buffer. Most buffers are well-formed strings with random content
  // mixing raw bytes, simple escapes and \u codes of one to three UTF-8 bytes. The rest
  // are broken: a byte overwritten by noise, a missing closing quote, a bad escape
  // or bad hex digit, or junk after the closing quote that must be dropped.
  function automatic byte_seq_t make_buffer();
    byte_seq_t   q;
    int          mode;
    int          pick;
    int          idx;
    logic [15:0] code;
    logic [3:0]  nib;
    mode = $urandom_range(0, 9);
    q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        q.push_back(raw_char());
      end else if (pick < 7) begin
        q.push_back(CH_BACKSLASH);
        case ($urandom_range(0, 7))
          0: q.push_back("\"");
          1: q.push_back("\\");
          2: q.push_back("/");
          3: q.push_back("b");
          4: q.push_back("f");
          5: q.push_back("n");
          6: q.push_back("r");
          default: q.push_back("t");
        endcase
      end else begin
        q.push_back(CH_BACKSLASH);
        q.push_back(CH_LOWER_U);
        case ($urandom_range(0, 2))
          0: code = 16'($urandom_range(0, 16'h007f));
          1: code = 16'($urandom_range(16'h0080, 16'h07ff));
          default: code = 16'($urandom_range(16'h0800, 16'hffff));
        endcase
        for (int k = 3; k >= 0; k--) begin
          nib = code[4*k +: 4];
          if (nib < 10) q.push_back(8'("0" + nib));
          else if ($urandom_range(0, 1) == 1) q.push_back(8'("a" + nib - 10));
          else q.push_back(8'("A" + nib - 10));
        end
      end
    end
    q.push_back(CH_QUOTE);
    case (mode)
      6: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      7: begin
        idx    = $urandom_range(0, q.size() - 1);
        q[idx] = 8'($urandom_range(0, 255));
      end
      8: void'(q.pop_back());
      9: begin
        // A backslash, or an unfinished \u, followed by a random byte.
        idx = $urandom_range(1, q.size() - 1);
        q.insert(idx, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) q.insert(idx, CH_LOWER_U);
        q.insert(idx, CH_BACKSLASH);
      end
      default: ;
    endcase
    return q;
  endfunction

  // Sends random buffers until at least the given number of bytes has gone in.
  task automatic run_random(input int n_bytes);
    byte_seq_t seq;
    int        sent;
    sent = 0;
    while (sent < n_bytes) begin
      seq = make_buffer();
      send_buffer(seq);
      sent += seq.size();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = '0;
    end_of_buffer = 1'b0;
    cfg_valid     = 1'b0;
    cap_wdata     = CAP_RESET;
    idling_on     = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed cases with the capacity at its reset value.
    // A first byte that is not a quote is an error.
    send_buffer('{8'h78});
    // The opening quote carrying the end-of-buffer flag is a missing close.
    send_buffer('{CH_QUOTE});
    // The highest raw byte, then a proper close.
    send_buffer('{CH_QUOTE, 8'hff, CH_QUOTE});
    // The largest code as three bytes and the largest two-byte code, then a bad
    // escape. The byte after the error is dropped up to the end of the buffer.
    send_buffer('{CH_QUOTE, CH_BACKSLASH, CH_LOWER_U, "F", "f", "f", "F",
                  CH_BACKSLASH, CH_LOWER_U, "0", "7", "f", "F",
                  CH_BACKSLASH, "q", "a"});
    // A raw control byte is an error.
    send_buffer('{CH_QUOTE, 8'h00, "a"});

    // Random buffers across a sweep of capacities, including zero and small
    // values that cut off two- and three-byte codes.
    write_capacity(16'd0);
    run_random(30);
    write_capacity(16'd1);
    run_random(30);
    write_capacity(16'd3);
    run_random(30);
    write_capacity(16'($urandom_range(2, 40)));
    run_random(60);

    // Final stretch at full capacity and full speed with no idling on either side.
    write_capacity(16'hffff);
    idling_on = 1'b0;
    run_random(60);

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit on run time, far above the slowest correct run.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
